/* sv/stba_pkg.sv */
`default_nettype none
package stba_pkg;

   localparam logic CMD_PUSH  = 1'b0;
   localparam logic CMD_CLEAR = 1'b1;

   localparam logic [1:0] KIND_ACC  = 2'd0;
   localparam logic [1:0] KIND_GYRO = 2'd1;
   localparam logic [1:0] KIND_MAG  = 2'd2;
   localparam logic [1:0] KIND_NONE = 2'd3;

   localparam logic [1:0] EMIT_FIRST = 2'd0;
   localparam logic [1:0] EMIT_LAST  = 2'd2;

   localparam int unsigned CSR_ADDR_BITS = 3;
   localparam int unsigned CSR_DATA_BITS = 32;
   localparam int unsigned PERIOD_BITS   = 16;
   localparam logic REG_ENGINE_ENABLE = 1'b0;
   localparam logic REG_FEED_PERIOD   = 1'b1;
   localparam logic [PERIOD_BITS-1:0] FEED_PERIOD_RESET = 16'd10;

   localparam int unsigned QUEUE_DEPTH = 2;

   typedef struct packed {
      logic       valid;
      logic       command;
      logic [1:0] kind;
   } queue_ctl_type;

   // batch order: gyro, mag, acc
   function automatic logic [1:0] emit_kind(input logic [1:0] idx);
      logic [1:0] kind;
      kind = KIND_ACC;
      case (idx)
         2'd0: kind = KIND_GYRO;
         2'd1: kind = KIND_MAG;
         default: kind = KIND_ACC;
      endcase
      return kind;
   endfunction

endpackage
`default_nettype wire

/* sv/sensor_triplet_batch_aligner.sv */
`default_nettype none
// channel   dir   handshake            payload
// req       in    req_tvalid/tready    tuser: command, sensor_kind; tdata: time, x, y, z
// rsp       out   rsp_tvalid/tready    tuser: out_kind; tdata: batch_time, x, y, z; tlast
// csr       in    apb psel/penable     engine_enable @0x0, feed_period @0x4
//
// a two-entry queue takes a beat each cycle while it has room
// a push runs the sequencer steps store, newest stamp and period gate, skipping the gate
// while a sensor is still missing; a clear acts in the idle state; pushes with the engine
// off are dropped at the queue; a batch adds 3 output beats, one per cycle without stall
// reset is synchronous; it empties the queue and the held store
// output stalls back up into the queue only, never into the csr port
module sensor_triplet_batch_aligner
   import stba_pkg::*;
#(
   parameter int unsigned SAMPLE_BITS = 32,
   parameter int unsigned TIME_BITS   = 48,
   localparam int unsigned DATA_BITS  = ((TIME_BITS + 3 * SAMPLE_BITS + 7) / 8) * 8
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_tvalid,
   output logic                          req_tready,
   input  wire logic [DATA_BITS-1:0]     req_tdata,  // sample_time, axis_x, axis_y, axis_z
   input  wire logic [2:0]               req_tuser,  // command, sensor_kind
   output logic                          rsp_tvalid,
   input  wire logic                     rsp_tready,
   output logic [DATA_BITS-1:0]          rsp_tdata,  // batch_time, out_x, out_y, out_z
   output logic [1:0]                    rsp_tuser,  // out_kind
   output logic                          rsp_tlast,
   input  wire logic                     csr_psel,
   input  wire logic                     csr_penable,
   input  wire logic                     csr_pwrite,
   input  wire logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  wire logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0]      csr_prdata,
   output logic                          csr_pready
);

   localparam int unsigned X_LSB = TIME_BITS;
   localparam int unsigned Y_LSB = TIME_BITS + SAMPLE_BITS;
   localparam int unsigned Z_LSB = TIME_BITS + 2 * SAMPLE_BITS;

   logic                   enable_ff, enable_in;
   logic [PERIOD_BITS-1:0] period_ff, period_in;
   logic                   csr_wr;
   logic                   csr_sel;

   queue_ctl_type          q_ctl;
   logic [TIME_BITS-1:0]   q_time;
   logic [SAMPLE_BITS-1:0] q_x, q_y, q_z;
   logic                   q_pop;

   logic [1:0]             out_kind;
   logic [TIME_BITS-1:0]   out_time;
   logic [SAMPLE_BITS-1:0] out_x, out_y, out_z;
   logic                   out_last;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_sel    = csr_paddr[2];

   always_comb begin
      enable_in = enable_ff;
      period_in = period_ff;
      if (csr_wr) begin
         unique case (csr_sel)
            REG_ENGINE_ENABLE: enable_in = csr_pwdata[0];
            REG_FEED_PERIOD:   period_in = csr_pwdata[PERIOD_BITS-1:0];
            default:           enable_in = enable_ff;
         endcase
      end
   end

   always_comb begin
      csr_prdata = '0;
      unique case (csr_sel)
         REG_ENGINE_ENABLE: csr_prdata[0] = enable_ff;
         REG_FEED_PERIOD:   csr_prdata[PERIOD_BITS-1:0] = period_ff;
         default:           csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b0;
         period_ff <= FEED_PERIOD_RESET;
      end else begin
         enable_ff <= enable_in;
         period_ff <= period_in;
      end
   end

   stba_front #(
      .SAMPLE_BITS(SAMPLE_BITS),
      .TIME_BITS  (TIME_BITS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .engine_enable(enable_ff),
      .in_valid     (req_tvalid),
      .in_ready     (req_tready),
      .in_command   (req_tuser[0]),
      .in_kind      (req_tuser[2:1]),
      .in_time      (req_tdata[TIME_BITS-1:0]),
      .in_x         (req_tdata[X_LSB +: SAMPLE_BITS]),
      .in_y         (req_tdata[Y_LSB +: SAMPLE_BITS]),
      .in_z         (req_tdata[Z_LSB +: SAMPLE_BITS]),
      .q_ctl        (q_ctl),
      .q_time       (q_time),
      .q_x          (q_x),
      .q_y          (q_y),
      .q_z          (q_z),
      .q_pop        (q_pop)
   );

   stba_back #(
      .SAMPLE_BITS(SAMPLE_BITS),
      .TIME_BITS  (TIME_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .feed_period(period_ff),
      .q_ctl      (q_ctl),
      .q_time     (q_time),
      .q_x        (q_x),
      .q_y        (q_y),
      .q_z        (q_z),
      .q_pop      (q_pop),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_kind   (out_kind),
      .out_time   (out_time),
      .out_x      (out_x),
      .out_y      (out_y),
      .out_z      (out_z),
      .out_last   (out_last)
   );

   always_comb begin
      rsp_tdata                           = '0;
      rsp_tdata[TIME_BITS-1:0]            = out_time;
      rsp_tdata[X_LSB +: SAMPLE_BITS]     = out_x;
      rsp_tdata[Y_LSB +: SAMPLE_BITS]     = out_y;
      rsp_tdata[Z_LSB +: SAMPLE_BITS]     = out_z;
   end

   assign rsp_tuser = out_kind;
   assign rsp_tlast = out_last;

`ifndef SYNTHESIS
   a_last_on_acc: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (rsp_tuser == KIND_ACC)))
      else $error("tlast not on the accelerometer beat");

   a_idle_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result beat straight after reset");

   a_gyro_then_mag: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && (rsp_tuser == KIND_GYRO))
      |=> (!rsp_tvalid || (rsp_tuser == KIND_MAG)))
      else $error("batch order broken after gyro beat");

   a_mag_then_acc: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && (rsp_tuser == KIND_MAG))
      |=> (!rsp_tvalid || (rsp_tuser == KIND_ACC)))
      else $error("batch order broken after mag beat");
`endif

endmodule
`default_nettype wire

/* sv/stba_front.sv */
`default_nettype none
module stba_front
   import stba_pkg::*;
#(
   parameter int unsigned SAMPLE_BITS = 32,
   parameter int unsigned TIME_BITS   = 48
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   engine_enable,
   input  wire logic                   in_valid,
   output logic                        in_ready,
   input  wire logic                   in_command,
   input  wire logic [1:0]             in_kind,
   input  wire logic [TIME_BITS-1:0]   in_time,
   input  wire logic [SAMPLE_BITS-1:0] in_x,
   input  wire logic [SAMPLE_BITS-1:0] in_y,
   input  wire logic [SAMPLE_BITS-1:0] in_z,
   output queue_ctl_type               q_ctl,
   output logic [TIME_BITS-1:0]        q_time,
   output logic [SAMPLE_BITS-1:0]      q_x,
   output logic [SAMPLE_BITS-1:0]      q_y,
   output logic [SAMPLE_BITS-1:0]      q_z,
   input  wire logic                   q_pop
);

   localparam int unsigned PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int unsigned CNT_BITS = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CNT_BITS-1:0] CNT_FULL = CNT_BITS'(QUEUE_DEPTH);
   localparam logic [PTR_BITS-1:0] PTR_LAST = PTR_BITS'(QUEUE_DEPTH - 1);

   logic                   ent_command_ff [QUEUE_DEPTH];
   logic [1:0]             ent_kind_ff    [QUEUE_DEPTH];
   logic [TIME_BITS-1:0]   ent_time_ff    [QUEUE_DEPTH];
   logic [SAMPLE_BITS-1:0] ent_x_ff       [QUEUE_DEPTH];
   logic [SAMPLE_BITS-1:0] ent_y_ff       [QUEUE_DEPTH];
   logic [SAMPLE_BITS-1:0] ent_z_ff       [QUEUE_DEPTH];

   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                store_en;

   assign in_ready = (count_ff != CNT_FULL);

   // disabled pushes are taken and dropped here
   assign store_en = in_valid && in_ready && ((in_command == CMD_CLEAR) || engine_enable);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (store_en) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (q_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CNT_BITS'(store_en) - CNT_BITS'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (store_en) begin
         ent_command_ff[wr_ptr_ff] <= in_command;
         ent_kind_ff[wr_ptr_ff]    <= in_kind;
         ent_time_ff[wr_ptr_ff]    <= in_time;
         ent_x_ff[wr_ptr_ff]       <= in_x;
         ent_y_ff[wr_ptr_ff]       <= in_y;
         ent_z_ff[wr_ptr_ff]       <= in_z;
      end
   end

   always_comb begin
      q_ctl.valid   = (count_ff != '0);
      q_ctl.command = ent_command_ff[rd_ptr_ff];
      q_ctl.kind    = ent_kind_ff[rd_ptr_ff];
      q_time        = ent_time_ff[rd_ptr_ff];
      q_x           = ent_x_ff[rd_ptr_ff];
      q_y           = ent_y_ff[rd_ptr_ff];
      q_z           = ent_z_ff[rd_ptr_ff];
   end

endmodule
`default_nettype wire

/* sv/stba_back.sv */
`default_nettype none
module stba_back
   import stba_pkg::*;
#(
   parameter int unsigned SAMPLE_BITS = 32,
   parameter int unsigned TIME_BITS   = 48
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic [PERIOD_BITS-1:0] feed_period,
   input  wire queue_ctl_type          q_ctl,
   input  wire logic [TIME_BITS-1:0]   q_time,
   input  wire logic [SAMPLE_BITS-1:0] q_x,
   input  wire logic [SAMPLE_BITS-1:0] q_y,
   input  wire logic [SAMPLE_BITS-1:0] q_z,
   output logic                        q_pop,
   output logic                        out_valid,
   input  wire logic                   out_ready,
   output logic [1:0]                  out_kind,
   output logic [TIME_BITS-1:0]        out_time,
   output logic [SAMPLE_BITS-1:0]      out_x,
   output logic [SAMPLE_BITS-1:0]      out_y,
   output logic [SAMPLE_BITS-1:0]      out_z,
   output logic                        out_last
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_MAX  = 4'b0010,
      ST_GATE = 4'b0100,
      ST_EMIT = 4'b1000
   } state_type;

   localparam int unsigned NUM_SENSORS = 3;

   state_type state_ff, state_in;

   logic [NUM_SENSORS-1:0] valid_ff, valid_in;
   logic [TIME_BITS-1:0]   stamp_ff [NUM_SENSORS];
   logic [SAMPLE_BITS-1:0] x_ff     [NUM_SENSORS];
   logic [SAMPLE_BITS-1:0] y_ff     [NUM_SENSORS];
   logic [SAMPLE_BITS-1:0] z_ff     [NUM_SENSORS];

   logic                 fed_ff, fed_in;
   logic [TIME_BITS-1:0] last_ff, last_in;
   logic [TIME_BITS-1:0] origin_ff, origin_in;
   logic [TIME_BITS-1:0] newest_ff, newest_in;
   logic [TIME_BITS-1:0] rel_ff, rel_in;
   logic [1:0]           idx_ff, idx_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [1:0]             rsp_kind_ff, rsp_kind_in;
   logic [TIME_BITS-1:0]   rsp_time_ff, rsp_time_in;
   logic [SAMPLE_BITS-1:0] rsp_x_ff, rsp_x_in;
   logic [SAMPLE_BITS-1:0] rsp_y_ff, rsp_y_in;
   logic [SAMPLE_BITS-1:0] rsp_z_ff, rsp_z_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic                 store_wr;
   logic                 out_free;
   logic [1:0]           cur_kind;
   logic [TIME_BITS-1:0] max01;
   logic [TIME_BITS-1:0] diff;
   logic                 pass;

   assign q_pop    = (state_ff == ST_IDLE) && q_ctl.valid;
   assign store_wr = q_pop && (q_ctl.command == CMD_PUSH) && (q_ctl.kind != KIND_NONE);
   assign out_free = !rsp_valid_ff || out_ready;
   assign cur_kind = emit_kind(idx_ff);

   assign max01 = (stamp_ff[KIND_GYRO] > stamp_ff[KIND_ACC]) ? stamp_ff[KIND_GYRO]
                                                             : stamp_ff[KIND_ACC];
   assign diff  = newest_ff - last_ff;
   assign pass  = !fed_ff ||
                  (!diff[TIME_BITS-1] &&
                   (diff >= {{(TIME_BITS-PERIOD_BITS){1'b0}}, feed_period}));

   always_comb begin
      state_in     = state_ff;
      valid_in     = valid_ff;
      fed_in       = fed_ff;
      last_in      = last_ff;
      origin_in    = origin_ff;
      newest_in    = newest_ff;
      rel_in       = rel_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_time_in  = rsp_time_ff;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_z_in     = rsp_z_ff;
      rsp_last_in  = rsp_last_ff;

      if (out_free) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (q_pop) begin
               if (q_ctl.command == CMD_CLEAR) begin
                  valid_in = '0;
                  fed_in   = 1'b0;
               end else begin
                  if (store_wr) begin
                     valid_in[q_ctl.kind] = 1'b1;
                  end
                  state_in = ST_MAX;
               end
            end
         end
         ST_MAX: begin
            newest_in = (stamp_ff[KIND_MAG] > max01) ? stamp_ff[KIND_MAG] : max01;
            state_in  = (&valid_ff) ? ST_GATE : ST_IDLE;
         end
         ST_GATE: begin
            if (pass) begin
               last_in = newest_ff;
               fed_in  = 1'b1;
               idx_in  = EMIT_FIRST;
               if (fed_ff) begin
                  rel_in = newest_ff - origin_ff;
               end else begin
                  origin_in = newest_ff;
                  rel_in    = '0;
               end
               state_in = ST_EMIT;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = cur_kind;
               rsp_time_in  = rel_ff;
               rsp_x_in     = x_ff[cur_kind];
               rsp_y_in     = y_ff[cur_kind];
               rsp_z_in     = z_ff[cur_kind];
               rsp_last_in  = (idx_ff == EMIT_LAST);
               idx_in       = idx_ff + 1'b1;
               if (idx_ff == EMIT_LAST) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         fed_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         fed_ff       <= fed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      last_ff     <= last_in;
      origin_ff   <= origin_in;
      newest_ff   <= newest_in;
      rel_ff      <= rel_in;
      idx_ff      <= idx_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_time_ff <= rsp_time_in;
      rsp_x_ff    <= rsp_x_in;
      rsp_y_ff    <= rsp_y_in;
      rsp_z_ff    <= rsp_z_in;
      rsp_last_ff <= rsp_last_in;
      if (store_wr) begin
         stamp_ff[q_ctl.kind] <= q_time;
         x_ff[q_ctl.kind]     <= q_x;
         y_ff[q_ctl.kind]     <= q_y;
         z_ff[q_ctl.kind]     <= q_z;
      end
   end

   assign out_valid = rsp_valid_ff;
   assign out_kind  = rsp_kind_ff;
   assign out_time  = rsp_time_ff;
   assign out_x     = rsp_x_ff;
   assign out_y     = rsp_y_ff;
   assign out_z     = rsp_z_ff;
   assign out_last  = rsp_last_ff;

endmodule
`default_nettype wire

/* sim/tb_sensor_triplet_batch_aligner.sv */
`timescale 1ns / 1ps
module tb_sensor_triplet_batch_aligner
   import stba_pkg::*;
();

   localparam int TIME_W        = 48;
   localparam int AXIS_W        = 32;
   localparam int DATA_W        = TIME_W + 3 * AXIS_W;
   localparam int CYCLE_LIMIT   = 300000;
   localparam int SETTLE_CYCLES = 24;
   localparam int HOLD_CYCLES   = 400;

   typedef logic [TIME_W-1:0] stamp_type;
   typedef logic [AXIS_W-1:0] axis_type;

   typedef struct packed {
      logic [1:0] kind;
      stamp_type  batch_time;
      axis_type   x;
      axis_type   y;
      axis_type   z;
      logic       last;
   } aligned_beat_type;

   typedef enum logic {ROW_PUSH, ROW_WRITE} row_op_type;

   typedef struct {
      row_op_type             op;
      logic                   cmd;
      logic [1:0]             kind;
      stamp_type              t;
      axis_type               x;
      axis_type               y;
      axis_type               z;
      int                     exp_n;
      stamp_type              exp_time;
      logic                   reg_idx;
      logic [CSR_DATA_BITS-1:0] reg_val;
   } plan_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [DATA_W-1:0]        req_tdata = '0;
   logic [2:0]               req_tuser = '0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [DATA_W-1:0]        rsp_tdata;
   logic [1:0]               rsp_tuser;
   logic                     rsp_tlast;
   logic                     csr_psel = 1'b0;
   logic                     csr_penable = 1'b0;
   logic                     csr_pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr = '0;
   logic [CSR_DATA_BITS-1:0] csr_pwdata = '0;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   sensor_triplet_batch_aligner #(
      .SAMPLE_BITS(AXIS_W),
      .TIME_BITS  (TIME_W)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   always #6 clock = ~clock;

   // aligner state as the block should hold it
   logic                   align_enable;
   logic [PERIOD_BITS-1:0] align_period;
   axis_type               held_axis [3][3];
   stamp_type              held_stamp [3];
   logic [2:0]             held_ok;
   stamp_type              last_batch;
   logic                   batch_fed;
   stamp_type              batch_origin;

   aligned_beat_type pending_batch_beats [$];
   plan_row_type     plan [$];

   int        beat_exp_n = -1;
   stamp_type beat_exp_time = '0;
   bit        idle_on = 1'b1;
   int        hold_token = 0;
   int        hold_taken = 0;
   int        hold_left = 0;
   int        errors = 0;
   int        cycles = 0;
   int        pushes_seen = 0;
   int        clears_seen = 0;
   int        batches_seen = 0;
   int        csr_writes = 0;

   task automatic clear_held();
      for (int s = 0; s < 3; s++) begin
         held_stamp[s] = '0;
         for (int a = 0; a < 3; a++) held_axis[s][a] = '0;
      end
      held_ok      = '0;
      last_batch   = '0;
      batch_fed    = 1'b0;
      batch_origin = '0;
   endtask

   task automatic predict_sample(input logic cmd, input logic [1:0] kind, input stamp_type t,
                                 input axis_type x, input axis_type y, input axis_type z,
                                 output int n, output stamp_type rel);
      stamp_type newest;
      stamp_type diff;
      n   = 0;
      rel = '0;
      if (cmd == CMD_CLEAR) begin
         clear_held();
         return;
      end
      if (!align_enable) return;
      if (kind != KIND_NONE) begin
         held_ok[kind]      = 1'b1;
         held_stamp[kind]   = t;
         held_axis[kind][0] = x;
         held_axis[kind][1] = y;
         held_axis[kind][2] = z;
      end
      if (held_ok != 3'b111) return;
      newest = held_stamp[KIND_ACC];
      if (held_stamp[KIND_GYRO] > newest) newest = held_stamp[KIND_GYRO];
      if (held_stamp[KIND_MAG] > newest) newest = held_stamp[KIND_MAG];
      if (batch_fed) begin
         diff = newest - last_batch;
         if (diff[TIME_W-1] || diff < stamp_type'(align_period)) return;
      end
      last_batch = newest;
      if (!batch_fed) begin
         batch_origin = newest;
         batch_fed    = 1'b1;
      end
      rel = newest - batch_origin;
      n   = 3;
   endtask

   // accepted request beats feed the predictor
   always @(posedge clock) begin
      int               n;
      stamp_type        rel;
      logic [1:0]       order [3];
      aligned_beat_type b;
      if (!reset && req_tvalid && req_tready) begin
         if (req_tuser[0] == CMD_CLEAR) clears_seen++;
         else pushes_seen++;
         predict_sample(req_tuser[0], req_tuser[2:1], req_tdata[TIME_W-1:0],
                        req_tdata[TIME_W +: AXIS_W], req_tdata[TIME_W+AXIS_W +: AXIS_W],
                        req_tdata[TIME_W+2*AXIS_W +: AXIS_W], n, rel);
         if (beat_exp_n >= 0 && (n != beat_exp_n || (n != 0 && rel !== beat_exp_time))) begin
            $display("%0t: table row mismatch, expected %0d beats at %0h, actual %0d at %0h",
                     $time, beat_exp_n, beat_exp_time, n, rel);
            errors++;
         end
         order[0] = KIND_GYRO;
         order[1] = KIND_MAG;
         order[2] = KIND_ACC;
         for (int k = 0; k < n; k++) begin
            b.kind       = order[k];
            b.batch_time = rel;
            b.x          = held_axis[order[k]][0];
            b.y          = held_axis[order[k]][1];
            b.z          = held_axis[order[k]][2];
            b.last       = (k == 2);
            pending_batch_beats.insert(pending_batch_beats.size(), b);
         end
      end
   end

   task automatic note_field(input string field, input logic [63:0] want,
                             input logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      aligned_beat_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (rsp_tlast) batches_seen++;
         if (pending_batch_beats.size() == 0) begin
            $display("%0t: unexpected result beat, expected none, actual kind %0d time %0h",
                     $time, rsp_tuser, rsp_tdata[TIME_W-1:0]);
            errors++;
         end else begin
            want = pending_batch_beats[0];
            pending_batch_beats.delete(0);
            note_field("out_kind", 64'(want.kind), 64'(rsp_tuser));
            note_field("batch_time", 64'(want.batch_time), 64'(rsp_tdata[TIME_W-1:0]));
            note_field("out_x", 64'(want.x), 64'(rsp_tdata[TIME_W +: AXIS_W]));
            note_field("out_y", 64'(want.y), 64'(rsp_tdata[TIME_W+AXIS_W +: AXIS_W]));
            note_field("out_z", 64'(want.z), 64'(rsp_tdata[TIME_W+2*AXIS_W +: AXIS_W]));
            note_field("batch_last", 64'(want.last), 64'(rsp_tlast));
         end
      end
   end

   // receiver with random stalls and an occasional long hold-off
   always @(posedge clock) begin
      if (hold_token != hold_taken) begin
         hold_taken = hold_token;
         hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !(idle_on && $urandom_range(99) < 19);
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d result beats outstanding", $time,
                  pending_batch_beats.size());
         $display("sensor_triplet_batch_aligner test failed");
         $finish;
      end
   end

   task automatic send_sample(input logic cmd, input logic [1:0] kind, input stamp_type t,
                              input axis_type x, input axis_type y, input axis_type z,
                              input int exp_n, input stamp_type exp_time);
      while (idle_on && $urandom_range(99) < 19) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid    <= 1'b1;
      req_tdata     <= {z, y, x, t};
      req_tuser     <= {kind, cmd};
      beat_exp_n    <= exp_n;
      beat_exp_time <= exp_time;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic drain_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_batch_beats.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic idx, input logic [CSR_DATA_BITS-1:0] value);
      logic [CSR_DATA_BITS-1:0] readback;
      if (idx == REG_ENGINE_ENABLE) readback = {31'b0, value[0]};
      else readback = {16'b0, value[PERIOD_BITS-1:0]};
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (idx == REG_ENGINE_ENABLE) align_enable = value[0];
      else align_period = value[PERIOD_BITS-1:0];
      csr_writes++;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_prdata !== readback) begin
         $display("%0t: register %0d readback mismatch, expected %0h, actual %0h",
                  $time, idx, readback, csr_prdata);
         errors++;
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic add_push(input logic cmd, input logic [1:0] kind, input stamp_type t,
                           input axis_type x, input axis_type y, input axis_type z,
                           input int exp_n, input stamp_type exp_time);
      plan_row_type r;
      r.op       = ROW_PUSH;
      r.cmd      = cmd;
      r.kind     = kind;
      r.t        = t;
      r.x        = x;
      r.y        = y;
      r.z        = z;
      r.exp_n    = exp_n;
      r.exp_time = exp_time;
      r.reg_idx  = 1'b0;
      r.reg_val  = '0;
      plan.insert(plan.size(), r);
   endtask

   task automatic add_write(input logic idx, input logic [CSR_DATA_BITS-1:0] value);
      plan_row_type r;
      r.op       = ROW_WRITE;
      r.cmd      = CMD_PUSH;
      r.kind     = KIND_ACC;
      r.t        = '0;
      r.x        = '0;
      r.y        = '0;
      r.z        = '0;
      r.exp_n    = -1;
      r.exp_time = '0;
      r.reg_idx  = idx;
      r.reg_val  = value;
      plan.insert(plan.size(), r);
   endtask

   task automatic run_random_phase(input int count, input logic [PERIOD_BITS-1:0] period,
                                   input stamp_type start, input bit calm, input bit with_hold);
      stamp_type  cur;
      stamp_type  t;
      int         r;
      int         step_max;
      logic       cmd;
      logic [1:0] kind;
      drain_idle();
      csr_write(REG_FEED_PERIOD, period);
      idle_on = !calm;
      if (with_hold) hold_token <= hold_token + 1;
      cur      = start;
      step_max = (period == 0) ? 4 : 2 * int'(period);
      for (int i = 0; i < count; i++) begin
         r    = $urandom_range(99);
         cmd  = (r < 4) ? CMD_CLEAR : CMD_PUSH;
         kind = (r < 9) ? KIND_NONE : 2'($urandom_range(2));
         r    = $urandom_range(99);
         if (r < 70) begin
            cur = cur + stamp_type'($urandom_range(step_max));
            t   = cur;
         end else if (r < 85) begin
            t = cur - stamp_type'($urandom_range(int'(period) + 5));
         end else if (r < 97) begin
            t = cur;
         end else begin
            cur = stamp_type'({$urandom, $urandom});
            t   = cur;
         end
         send_sample(cmd, kind, t, $urandom, $urandom, $urandom, -1, '0);
      end
      idle_on = 1'b1;
   endtask

   initial begin
      stamp_type t_max;
      t_max        = '1;
      align_enable = 1'b0;
      align_period = FEED_PERIOD_RESET;
      clear_held();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // engine off after reset: pushes are dropped
      add_push(CMD_PUSH, KIND_ACC, 48'd1, 32'h7fffffff, 32'h80000000, 32'h0, 0, '0);
      add_push(CMD_PUSH, KIND_GYRO, 48'd1, 32'h1, 32'hffffffff, 32'h0, 0, '0);
      add_push(CMD_PUSH, KIND_MAG, 48'd1, 32'h0, 32'h0, 32'h0, 0, '0);
      add_write(REG_ENGINE_ENABLE, 32'h1);
      add_push(CMD_PUSH, KIND_ACC, 48'd100, 32'h7fffffff, 32'h80000000, 32'h0, 0, '0);
      add_push(CMD_PUSH, KIND_GYRO, 48'd100, 32'h80000000, 32'h7fffffff, 32'hffffffff, 0, '0);
      add_push(CMD_PUSH, KIND_MAG, 48'd105, 32'h00010000, 32'hffff0000, 32'h1, 3, 48'd0);
      add_push(CMD_PUSH, KIND_ACC, 48'd110, 32'h1, 32'h2, 32'h3, 0, '0);
      add_push(CMD_PUSH, KIND_GYRO, 48'd115, 32'h4, 32'h5, 32'h6, 3, 48'd10);
      // stamp behind the others, then an unknown sensor
      add_push(CMD_PUSH, KIND_MAG, 48'd50, 32'h7, 32'h8, 32'h9, 0, '0);
      add_push(CMD_PUSH, KIND_NONE, 48'd999, 32'hdeadbeef, 32'h0, 32'h0, 0, '0);
      add_push(CMD_PUSH, KIND_ACC, 48'd125, 32'hffffffff, 32'h0, 32'h7fffffff, 3, 48'd20);
      // newest far ahead reads as a negative step
      add_push(CMD_PUSH, KIND_GYRO, t_max, 32'h0, 32'h0, 32'h0, 0, '0);
      add_push(CMD_CLEAR, KIND_ACC, '0, 32'h0, 32'h0, 32'h0, 0, '0);
      // timestamp wrap after clear
      add_push(CMD_PUSH, KIND_ACC, t_max, 32'hffffffff, 32'hffffffff, 32'hffffffff, 0, '0);
      add_push(CMD_PUSH, KIND_GYRO, 48'd0, 32'h80000000, 32'h80000000, 32'h80000000, 0, '0);
      add_push(CMD_PUSH, KIND_MAG, 48'd0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 3, 48'd0);
      add_push(CMD_PUSH, KIND_ACC, 48'd5, 32'h1, 32'h1, 32'h1, 0, '0);
      add_push(CMD_PUSH, KIND_ACC, 48'd9, 32'h2, 32'h2, 32'h2, 3, 48'd10);
      // zero period: same stamp passes
      add_write(REG_FEED_PERIOD, 32'h0);
      add_push(CMD_PUSH, KIND_ACC, 48'd9, 32'h3, 32'h3, 32'h3, 3, 48'd10);
      add_write(REG_FEED_PERIOD, 32'hffff);
      add_push(CMD_PUSH, KIND_GYRO, 48'd10, 32'h4, 32'h4, 32'h4, 0, '0);
      add_push(CMD_PUSH, KIND_MAG, 48'd65544, 32'h5, 32'h5, 32'h5, -1, '0);
      // clear still works with the engine off
      add_write(REG_ENGINE_ENABLE, 32'h0);
      add_push(CMD_CLEAR, KIND_NONE, t_max, 32'h0, 32'h0, 32'h0, 0, '0);
      add_write(REG_ENGINE_ENABLE, 32'h1);
      add_push(CMD_PUSH, KIND_ACC, 48'd7, 32'h11, 32'h12, 32'h13, 0, '0);
      add_push(CMD_PUSH, KIND_GYRO, 48'd7, 32'h21, 32'h22, 32'h23, 0, '0);
      add_push(CMD_PUSH, KIND_MAG, 48'd7, 32'h31, 32'h32, 32'h33, 3, 48'd0);

      foreach (plan[i]) begin
         if (plan[i].op == ROW_WRITE) begin
            drain_idle();
            csr_write(plan[i].reg_idx, plan[i].reg_val);
         end else begin
            send_sample(plan[i].cmd, plan[i].kind, plan[i].t, plan[i].x, plan[i].y,
                        plan[i].z, plan[i].exp_n, plan[i].exp_time);
         end
      end

      run_random_phase(90, 16'd1, '1 - 48'd60, 1'b0, 1'b1);
      run_random_phase(90, 16'($urandom_range(2, 40)), 48'($urandom), 1'b1, 1'b0);
      run_random_phase(90, 16'hffff, 48'd0, 1'b0, 1'b0);
      run_random_phase(90, 16'd0, 48'($urandom), 1'b0, 1'b0);
      drain_idle();

      $display("covered %0d pushes and %0d clears over %0d register writes,", pushes_seen,
               clears_seen, csr_writes);
      $display("with %0d aligned batches checked beat by beat", batches_seen);
      if (errors == 0 && pending_batch_beats.size() == 0) begin
         $display("sensor_triplet_batch_aligner test passed");
      end else begin
         $display("sensor_triplet_batch_aligner test failed");
      end
      $finish;
   end

endmodule
